@@ rtl/core/tpab_pkg.sv @@
package tpab_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 8;

    // configuration register indexes
    localparam logic [CfgIndexWidth-1:0] REG_FORMAT_MODE = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_ALPHA_TEST  = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_TINT_RED    = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_TINT_GREEN  = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_TINT_BLUE   = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_TINT_ALPHA  = 3'd5;

    // format modes
    localparam logic [1:0] FMT_565_TO_565   = 2'd0;
    localparam logic [1:0] FMT_4444_TO_565  = 2'd1;
    localparam logic [1:0] FMT_4444_TO_4444 = 2'd2;

    // alpha product at full source alpha and full tint alpha
    localparam logic [11:0] ALPHA_PROD_MAX = 12'd3825;

    typedef struct packed {
        logic [15:0] src_pixel;
        logic [15:0] dst_pixel;
    } pixel_in_t;

    typedef struct packed {
        logic [15:0] out_pixel;
        logic        write_enable;
    } pixel_out_t;

    typedef struct packed {
        logic [1:0] format_mode;
        logic       alpha_test;
        logic [3:0] tint_red;
        logic [3:0] tint_green;
        logic [3:0] tint_blue;
        logic [7:0] tint_alpha;
    } cfg_t;

    // floor(c * (k + 1) / 16)
    function automatic logic [5:0] scale_ch(input logic [5:0] c, input logic [3:0] k);
        logic [4:0] kp;
        logic [9:0] prod;
        kp   = {1'b0, k} + 5'd1;
        prod = {4'd0, c} * {5'd0, kp};
        return prod[9:4];
    endfunction

    // floor(x / 255) for x up to 3825
    function automatic logic [3:0] div255(input logic [11:0] x);
        logic [12:0] s;
        s = {1'b0, x} + 13'd1 + {9'd0, x[11:8]};
        return s[11:8];
    endfunction

endpackage

@@ rtl/core/tpab_cfg.sv @@
module tpab_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [tpab_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [tpab_pkg::CfgDataWidth-1:0]    cfg_data,
    output tpab_pkg::cfg_t                       cfg
);

    tpab_pkg::cfg_t cfg_reg;
    tpab_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                tpab_pkg::REG_FORMAT_MODE: cfg_next.format_mode = cfg_data[1:0];
                tpab_pkg::REG_ALPHA_TEST:  cfg_next.alpha_test  = cfg_data[0];
                tpab_pkg::REG_TINT_RED:    cfg_next.tint_red    = cfg_data[3:0];
                tpab_pkg::REG_TINT_GREEN:  cfg_next.tint_green  = cfg_data[3:0];
                tpab_pkg::REG_TINT_BLUE:   cfg_next.tint_blue   = cfg_data[3:0];
                tpab_pkg::REG_TINT_ALPHA:  cfg_next.tint_alpha  = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.format_mode <= tpab_pkg::FMT_565_TO_565;
            cfg_reg.alpha_test  <= 1'b0;
            cfg_reg.tint_red    <= 4'hF;
            cfg_reg.tint_green  <= 4'hF;
            cfg_reg.tint_blue   <= 4'hF;
            cfg_reg.tint_alpha  <= 8'hFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/tinted_pixel_alpha_blend.sv @@
// Tinted alpha blend pixel path of a 2D blitter.
// pair channel: one source/destination pixel pair per transfer (pair_valid,
// pair_stall driven by this block). result channel: new destination pixel and
// write enable per transfer (result_valid, result_stall driven by receiver).
// cfg channel: register index and data, written when cfg_valid and cfg_ready
// are high; cfg_ready is always high. Write registers only while the block
// holds no items.
// Four register stages: alpha product, alpha/inverse indexes with source
// tint, scaled blend sums with saturation, final tint and format select.
// A transferred pair passes through the stage registers in order, and
// result_valid rises when it reaches the last stage; a new pair is taken
// every cycle while the result side keeps up.
// Each stage loads when it is empty or its successor moves, so bubbles are
// squeezed out under a result stall and pair_stall rises only when all four
// stages are full.
// Reset empties the pipeline and sets format 0, no alpha test, white tint.
module tinted_pixel_alpha_blend (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pair_valid,
    output logic                                 pair_stall,
    input  tpab_pkg::pixel_in_t                  pair,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output tpab_pkg::pixel_out_t                 result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tpab_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [tpab_pkg::CfgDataWidth-1:0]    cfg_data
);

    tpab_pkg::cfg_t cfg;

    tpab_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign cfg_ready = 1'b1;

    // stage valids and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld1, ld2, ld3, ld4;

    assign ld4 = !v4_reg || !result_stall;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign pair_stall = !ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= pair_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
        end
    end

    // stage 1: alpha product
    logic [15:0] src1_reg, dst1_reg;
    logic [11:0] prod1_reg, prod1_next;

    assign prod1_next = {8'd0, pair.src_pixel[3:0]} * {4'd0, cfg.tint_alpha};

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            src1_reg  <= pair.src_pixel;
            dst1_reg  <= pair.dst_pixel;
            prod1_reg <= prod1_next;
        end
    end

    // stage 2: alpha indexes, converted and tinted source for the 565 blend
    logic [15:0] src2_reg, dst2_reg;
    logic [3:0]  ai2_reg, ai2_next, ii2_reg, ii2_next;
    logic [4:0]  tr2_reg, tb2_reg;
    logic [5:0]  tg2_reg;
    logic [5:0]  tr2_next, tg2_next, tb2_next;
    logic [4:0]  cr1, cb1;
    logic [5:0]  cg1;

    assign cr1 = {src1_reg[15:12], src1_reg[15]};
    assign cg1 = {src1_reg[11:8], src1_reg[11:10]};
    assign cb1 = {src1_reg[7:4], src1_reg[7]};

    always_comb
    begin
        ai2_next = tpab_pkg::div255(prod1_reg);
        ii2_next = tpab_pkg::div255(tpab_pkg::ALPHA_PROD_MAX - prod1_reg);
        tr2_next = tpab_pkg::scale_ch({1'b0, cr1}, cfg.tint_red);
        tg2_next = tpab_pkg::scale_ch(cg1, cfg.tint_green);
        tb2_next = tpab_pkg::scale_ch({1'b0, cb1}, cfg.tint_blue);
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            src2_reg <= src1_reg;
            dst2_reg <= dst1_reg;
            ai2_reg  <= ai2_next;
            ii2_reg  <= ii2_next;
            tr2_reg  <= tr2_next[4:0];
            tg2_reg  <= tg2_next;
            tb2_reg  <= tb2_next[4:0];
        end
    end

    // stage 3: scaled blend sums, saturated for the destination format
    logic [15:0] src3_reg, dst3_reg;
    logic [5:0]  sr3_reg, sg3_reg, sb3_reg;
    logic [5:0]  sr3_next, sg3_next, sb3_next;
    logic [5:0]  pr, pg, pb, dr, dg, db;
    logic [5:0]  qr, qg, qb, er, eg, eb;
    logic [6:0]  sum_r, sum_g, sum_b;
    logic [6:0]  nib_r, nib_g, nib_b;

    always_comb
    begin
        pr = tpab_pkg::scale_ch({1'b0, tr2_reg}, ai2_reg);
        pg = tpab_pkg::scale_ch(tg2_reg, ai2_reg);
        pb = tpab_pkg::scale_ch({1'b0, tb2_reg}, ai2_reg);
        dr = tpab_pkg::scale_ch({1'b0, dst2_reg[15:11]}, ii2_reg);
        dg = tpab_pkg::scale_ch(dst2_reg[10:5], ii2_reg);
        db = tpab_pkg::scale_ch({1'b0, dst2_reg[4:0]}, ii2_reg);
        qr = tpab_pkg::scale_ch({2'b0, src2_reg[15:12]}, ai2_reg);
        qg = tpab_pkg::scale_ch({2'b0, src2_reg[11:8]}, ai2_reg);
        qb = tpab_pkg::scale_ch({2'b0, src2_reg[7:4]}, ai2_reg);
        er = tpab_pkg::scale_ch({2'b0, dst2_reg[15:12]}, ii2_reg);
        eg = tpab_pkg::scale_ch({2'b0, dst2_reg[11:8]}, ii2_reg);
        eb = tpab_pkg::scale_ch({2'b0, dst2_reg[7:4]}, ii2_reg);
        sum_r = {1'b0, pr} + {1'b0, dr};
        sum_g = {1'b0, pg} + {1'b0, dg};
        sum_b = {1'b0, pb} + {1'b0, db};
        nib_r = {1'b0, qr} + {1'b0, er};
        nib_g = {1'b0, qg} + {1'b0, eg};
        nib_b = {1'b0, qb} + {1'b0, eb};
        if (cfg.format_mode == tpab_pkg::FMT_4444_TO_565)
        begin
            sr3_next = (sum_r > 7'd31) ? 6'd31 : sum_r[5:0];
            sg3_next = (sum_g > 7'd63) ? 6'd63 : sum_g[5:0];
            sb3_next = (sum_b > 7'd31) ? 6'd31 : sum_b[5:0];
        end
        else
        begin
            sr3_next = (nib_r > 7'd15) ? 6'd15 : nib_r[5:0];
            sg3_next = (nib_g > 7'd15) ? 6'd15 : nib_g[5:0];
            sb3_next = (nib_b > 7'd15) ? 6'd15 : nib_b[5:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            src3_reg <= src2_reg;
            dst3_reg <= dst2_reg;
            sr3_reg  <= sr3_next;
            sg3_reg  <= sg3_next;
            sb3_reg  <= sb3_next;
        end
    end

    // stage 4: final tint and format select
    tpab_pkg::pixel_out_t res4_reg, res4_next;
    logic       white;
    logic [3:0] vr, vg, vb;
    logic [5:0] m0r, m0g, m0b, t2r, t2g, t2b;

    assign white = (cfg.tint_red == 4'hF) && (cfg.tint_green == 4'hF)
                && (cfg.tint_blue == 4'hF) && (cfg.tint_alpha == 8'hFF);

    always_comb
    begin
        vr  = cfg.alpha_test ? src3_reg[15:12] : sr3_reg[3:0];
        vg  = cfg.alpha_test ? src3_reg[11:8]  : sg3_reg[3:0];
        vb  = cfg.alpha_test ? src3_reg[7:4]   : sb3_reg[3:0];
        m0r = tpab_pkg::scale_ch({1'b0, src3_reg[15:11]}, cfg.tint_red);
        m0g = tpab_pkg::scale_ch(src3_reg[10:5], cfg.tint_green);
        m0b = tpab_pkg::scale_ch({1'b0, src3_reg[4:0]}, cfg.tint_blue);
        t2r = tpab_pkg::scale_ch({2'b0, vr}, cfg.tint_red);
        t2g = tpab_pkg::scale_ch({2'b0, vg}, cfg.tint_green);
        t2b = tpab_pkg::scale_ch({2'b0, vb}, cfg.tint_blue);
        res4_next.out_pixel    = dst3_reg;
        res4_next.write_enable = 1'b0;
        case (cfg.format_mode)
            tpab_pkg::FMT_565_TO_565:
            begin
                res4_next.out_pixel    = {m0r[4:0], m0g, m0b[4:0]};
                res4_next.write_enable = 1'b1;
            end
            tpab_pkg::FMT_4444_TO_565:
            begin
                if (src3_reg[3:0] != 4'd0)
                begin
                    res4_next.write_enable = 1'b1;
                    if (cfg.alpha_test && white)
                        res4_next.out_pixel = {src3_reg[15:12], src3_reg[15],
                                               src3_reg[11:8], src3_reg[11:10],
                                               src3_reg[7:4], src3_reg[7]};
                    else
                        res4_next.out_pixel = {sr3_reg[4:0], sg3_reg, sb3_reg[4:0]};
                end
            end
            tpab_pkg::FMT_4444_TO_4444:
            begin
                if (src3_reg[3:0] != 4'd0)
                begin
                    res4_next.write_enable = 1'b1;
                    if (cfg.alpha_test && white)
                        res4_next.out_pixel = src3_reg;
                    else
                        res4_next.out_pixel = {t2r[3:0], t2g[3:0], t2b[3:0], 4'hF};
                end
            end
            default:
            begin
                res4_next.out_pixel    = dst3_reg;
                res4_next.write_enable = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
            res4_reg <= res4_next;
    end

    assign result_valid = v4_reg;
    assign result       = res4_reg;

    // pair side stalls only with every stage full and the result blocked
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pair_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && result_stall))
        else $error("pair stalled with an empty stage");

    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid && !pair_stall) |=> v1_reg)
        else $error("accepted pair not held in stage 1");

    a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && v4_reg && result_stall) |=> (v3_reg && $stable(src3_reg)))
        else $error("stage 3 item lost under stall");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !v3_reg) |=> !result_valid)
        else $error("result repeated after transfer");

endmodule
